>>> sv/depth_sorted_primitive_list_macros.svh
// Assertion macros shared by the depth sorter RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef DEPTH_SORTED_PRIMITIVE_LIST_MACROS_SVH
`define DEPTH_SORTED_PRIMITIVE_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DSPL_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DSPL_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Invariant that holds at every edge out of reset
`define DSPL_ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  `DSPL_ASSERT_IMPL(lbl, ck, rs, 1'b1, cond, msg)

`endif

>>> sv/dspl_pkg.sv
// Shared types and codes of the depth sorter: operation and status codes, result record.
// No dependencies; used by every module of the block except dspl_ram.
package dspl_pkg;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 7;
  localparam int COUNT_W    = 4;
  localparam int COLOUR_W   = 8;
  localparam int COORD_W    = 16;
  localparam int VERTEX_W   = 2 * COORD_W;
  localparam int DEPTH_W    = 32;
  localparam int CC_W       = COLOUR_W + COUNT_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;

  // Most vertex pairs emitted for one entry
  localparam int MAX_EMIT = 8;

  // Operation codes (carried on s_tuser)
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_VERTEX = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_EMIT   = 2'd3;

  // Result status codes (carried on m_tuser)
  localparam logic [STATUS_W-1:0] STATUS_VERTEX   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_END      = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_OUT_W-1:0]    entry_slot;
    logic [COUNT_W-1:0]       point_count;
    logic [COLOUR_W-1:0]      colour;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                     last;
  } result_t;

endpackage

>>> sv/depth_sorted_primitive_list.sv
// Depth-sorted primitive list: painter's-order linked list over an entry RAM and a vertex RAM.
// Clear and vertex complete from idle; insert copies the staged pairs into the vertex RAM, then
// walks the entry RAM from the head to its place (not for an empty list) and links the entry in.
// Emit reads the entry, then reads and presents each vertex pair in turn; end of list from idle.
// One operation at a time. Reset clears the list, drain state and staged pairs;
// the RAMs are not swept and are written before they are read.
`include "depth_sorted_primitive_list_macros.svh"

module depth_sorted_primitive_list #(
  parameter int MAX_ENTRIES = 128,
  parameter int POINT_WORDS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // vertex_index[2:0], vertex_x[18:3], vertex_y[34:19], point_count[38:35],
  // colour[46:39], depth[78:47], zero fill [79]
  input  logic [dspl_pkg::IN_DATA_W-1:0]     s_tdata,
  // op[1:0]
  input  logic [dspl_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // entry_slot[6:0], out_point_count[10:7], out_colour[18:11], out_x[34:19],
  // out_y[50:35], zero fill [55:51]
  output logic [dspl_pkg::OUT_DATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic [dspl_pkg::STATUS_W-1:0]      m_tuser,
  output logic                               m_tlast
);

  localparam int PAIRS    = POINT_WORDS / 2;
  localparam int SW       = $clog2(MAX_ENTRIES);
  localparam int CW       = $clog2(MAX_ENTRIES + 1);
  localparam int PIW      = $clog2(PAIRS);
  localparam int VDEPTH   = MAX_ENTRIES * PAIRS;
  localparam int VAW      = $clog2(VDEPTH);
  localparam int EMIT_CAP = (PAIRS < dspl_pkg::MAX_EMIT) ? PAIRS : dspl_pkg::MAX_EMIT;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_COPY      = 4'd1;
  localparam logic [3:0] ST_HEAD      = 4'd2;
  localparam logic [3:0] ST_WALK      = 4'd3;
  localparam logic [3:0] ST_LINK_NEW  = 4'd4;
  localparam logic [3:0] ST_LINK_CUR  = 4'd5;
  localparam logic [3:0] ST_EMIT_ENT  = 4'd6;
  localparam logic [3:0] ST_EMIT_REQ  = 4'd7;
  localparam logic [3:0] ST_EMIT_DATA = 4'd8;

  typedef struct packed {
    logic signed [dspl_pkg::DEPTH_W-1:0] key;
    logic [dspl_pkg::CC_W-1:0]           cc;
    logic                                valid;
    logic [SW-1:0]                       link;
  } ent_t;

  localparam int EW = $bits(ent_t);

  // Input fields
  logic [dspl_pkg::OP_W-1:0]            in_op;
  logic [2:0]                           in_vidx;
  logic [dspl_pkg::VERTEX_W-1:0]        in_vertex;
  logic [dspl_pkg::COUNT_W-1:0]         in_count;
  logic [dspl_pkg::COLOUR_W-1:0]        in_colour;
  logic signed [dspl_pkg::DEPTH_W-1:0]  in_depth;

  assign in_op     = s_tuser;
  assign in_vidx   = s_tdata[2:0];
  assign in_vertex = {s_tdata[34:19], s_tdata[18:3]};
  assign in_count  = s_tdata[38:35];
  assign in_colour = s_tdata[46:39];
  assign in_depth  = s_tdata[78:47];

  // Control state
  logic [3:0]    state, state_next;
  logic [CW-1:0] entry_count;
  logic [SW-1:0] head;
  logic          drain_started;
  logic          drain_done;
  logic [SW-1:0] drain_cursor;

  // Working registers of the operation in flight
  logic [SW-1:0]                       new_slot;
  logic signed [dspl_pkg::DEPTH_W-1:0] new_key;
  logic [dspl_pkg::CC_W-1:0]           new_cc;
  logic                                new_valid;
  logic [SW-1:0]                       new_link;
  logic                                link_cur;
  logic [SW-1:0]                       cur;
  ent_t                                cur_ent;
  ent_t                                emit_ent;
  logic [PIW-1:0]                      pair_idx;
  logic [dspl_pkg::COUNT_W-1:0]        emit_n;

  // RAM and submodule connections
  logic          ent_we, ent_re;
  logic [SW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  ent_t          ent_rd;
  logic          vtx_we, vtx_re;
  logic [VAW-1:0] vtx_addr;
  logic [SW-1:0]  vtx_slot;
  logic [dspl_pkg::VERTEX_W-1:0] vtx_rdata, stage_rdata;
  logic           stage_we;
  logic           out_load, out_free;
  dspl_pkg::result_t out_res;

  logic          s_acc;
  logic          full;
  logic          copy_last;
  logic [SW-1:0] cursor_e;
  logic          done_e;
  logic          end_of_list;
  logic [dspl_pkg::COUNT_W-1:0] rd_n;
  logic          emit_last;

  assign ent_rd    = ent_t'(ent_rdata);
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign s_acc     = s_tvalid && s_tready;
  assign full      = entry_count == CW'(MAX_ENTRIES);
  assign copy_last = pair_idx == PIW'(PAIRS - 1);
  assign stage_we  = s_acc && (in_op == dspl_pkg::OP_VERTEX);

  // Drain position seen by an emit: a fresh drain starts at the head
  assign cursor_e    = drain_started ? drain_cursor : head;
  assign done_e      = drain_started ? drain_done : (entry_count == '0);
  assign end_of_list = done_e || (CW'(cursor_e) >= entry_count);

  // Pairs emitted for the entry just read, capped by the store and the result limit
  assign rd_n = (ent_rd.cc[dspl_pkg::COUNT_W-1:0] > dspl_pkg::COUNT_W'(EMIT_CAP))
              ? dspl_pkg::COUNT_W'(EMIT_CAP) : ent_rd.cc[dspl_pkg::COUNT_W-1:0];
  assign emit_last = (dspl_pkg::COUNT_W'(pair_idx) + dspl_pkg::COUNT_W'(1)) == emit_n;

  // Vertex RAM address: slot row plus pair
  assign vtx_slot = (state == ST_COPY) ? new_slot : drain_cursor;
  assign vtx_addr = VAW'(VAW'(vtx_slot) * VAW'(PAIRS) + VAW'(pair_idx));
  assign vtx_we   = state == ST_COPY;
  assign vtx_re   = (state == ST_EMIT_REQ) && out_free;

  // Entry RAM read and write selection
  always_comb begin
    ent_re    = 1'b0;
    ent_raddr = cursor_e;
    ent_we    = 1'b0;
    ent_waddr = new_slot;
    ent_wdata = EW'({new_key, new_cc, new_valid, new_link});
    case (state)
      ST_IDLE: begin
        ent_re    = s_acc && (in_op == dspl_pkg::OP_EMIT) && !end_of_list;
        ent_raddr = cursor_e;
      end
      ST_COPY: begin
        ent_re    = copy_last && (new_slot != '0);
        ent_raddr = head;
      end
      ST_HEAD: begin
        ent_re    = ent_rd.valid;
        ent_raddr = ent_rd.link;
      end
      ST_WALK: begin
        ent_re    = ent_rd.valid;
        ent_raddr = ent_rd.link;
      end
      ST_LINK_NEW: begin
        ent_we = 1'b1;
      end
      ST_LINK_CUR: begin
        ent_we    = 1'b1;
        ent_waddr = cur;
        ent_wdata = EW'({cur_ent.key, cur_ent.cc, 1'b1, new_slot});
      end
      default: begin
        ent_re = 1'b0;
      end
    endcase
  end

  // Result selection
  always_comb begin
    out_load = 1'b0;
    out_res  = '0;
    out_res.last = 1'b1;
    case (state)
      ST_IDLE: begin
        if (s_acc && (in_op == dspl_pkg::OP_INSERT) && full) begin
          out_load       = 1'b1;
          out_res.status = dspl_pkg::STATUS_FULL;
        end else if (s_acc && (in_op == dspl_pkg::OP_EMIT) && end_of_list) begin
          out_load       = 1'b1;
          out_res.status = dspl_pkg::STATUS_END;
        end
      end
      ST_LINK_NEW: begin
        out_load           = !link_cur;
        out_res.status     = dspl_pkg::STATUS_INSERTED;
        out_res.entry_slot = dspl_pkg::SLOT_OUT_W'(new_slot);
      end
      ST_LINK_CUR: begin
        out_load           = 1'b1;
        out_res.status     = dspl_pkg::STATUS_INSERTED;
        out_res.entry_slot = dspl_pkg::SLOT_OUT_W'(new_slot);
      end
      ST_EMIT_ENT: begin
        out_load            = rd_n == '0;
        out_res.status      = dspl_pkg::STATUS_VERTEX;
        out_res.entry_slot  = dspl_pkg::SLOT_OUT_W'(drain_cursor);
        out_res.point_count = ent_rd.cc[dspl_pkg::COUNT_W-1:0];
        out_res.colour      = ent_rd.cc[dspl_pkg::CC_W-1:dspl_pkg::COUNT_W];
      end
      ST_EMIT_DATA: begin
        out_load            = 1'b1;
        out_res.status      = dspl_pkg::STATUS_VERTEX;
        out_res.entry_slot  = dspl_pkg::SLOT_OUT_W'(drain_cursor);
        out_res.point_count = emit_ent.cc[dspl_pkg::COUNT_W-1:0];
        out_res.colour      = emit_ent.cc[dspl_pkg::CC_W-1:dspl_pkg::COUNT_W];
        out_res.x           = vtx_rdata[dspl_pkg::COORD_W-1:0];
        out_res.y           = vtx_rdata[dspl_pkg::VERTEX_W-1:dspl_pkg::COORD_W];
        out_res.last        = emit_last;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc && (in_op == dspl_pkg::OP_INSERT) && !full) begin
          state_next = ST_COPY;
        end else if (s_acc && (in_op == dspl_pkg::OP_EMIT) && !end_of_list) begin
          state_next = ST_EMIT_ENT;
        end
      end
      ST_COPY: begin
        if (copy_last) begin
          state_next = (new_slot == '0) ? ST_LINK_NEW : ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (ent_rd.key < new_key || !ent_rd.valid) begin
          state_next = ST_LINK_NEW;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ent_rd.key < new_key || !ent_rd.valid) begin
          state_next = ST_LINK_NEW;
        end
      end
      ST_LINK_NEW: begin
        state_next = link_cur ? ST_LINK_CUR : ST_IDLE;
      end
      ST_LINK_CUR: begin
        state_next = ST_IDLE;
      end
      ST_EMIT_ENT: begin
        state_next = (rd_n == '0) ? ST_IDLE : ST_EMIT_REQ;
      end
      ST_EMIT_REQ: begin
        if (out_free) begin
          state_next = ST_EMIT_DATA;
        end
      end
      ST_EMIT_DATA: begin
        state_next = emit_last ? ST_IDLE : ST_EMIT_REQ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: list head, fill count and drain position
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      head          <= '0;
      drain_started <= 1'b0;
      drain_done    <= 1'b0;
      drain_cursor  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (s_acc && (in_op == dspl_pkg::OP_CLEAR)) begin
            entry_count   <= '0;
            head          <= '0;
            drain_started <= 1'b0;
            drain_done    <= 1'b0;
          end else if (s_acc && (in_op == dspl_pkg::OP_INSERT) && !full) begin
            entry_count   <= entry_count + CW'(1);
            drain_started <= 1'b0;
            drain_done    <= 1'b0;
          end else if (s_acc && (in_op == dspl_pkg::OP_EMIT)) begin
            drain_started <= 1'b1;
            drain_cursor  <= cursor_e;
            drain_done    <= end_of_list;
          end
        end
        ST_COPY: begin
          if (copy_last && (new_slot == '0)) begin
            head <= '0;
          end
        end
        ST_HEAD: begin
          if (ent_rd.key < new_key) begin
            head <= new_slot;
          end
        end
        ST_EMIT_ENT: begin
          // Advance the drain after an entry with no pairs
          if (rd_n == '0) begin
            if (ent_rd.valid) begin
              drain_cursor <= ent_rd.link;
            end else begin
              drain_done <= 1'b1;
            end
          end
        end
        ST_EMIT_DATA: begin
          if (emit_last) begin
            if (emit_ent.valid) begin
              drain_cursor <= emit_ent.link;
            end else begin
              drain_done <= 1'b1;
            end
          end
        end
        default: begin
          drain_done <= drain_done;
        end
      endcase
    end
  end

  // Working registers: new entry, walk cursor, emit entry and pair counter
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        new_slot <= SW'(entry_count);
        new_key  <= in_depth;
        new_cc   <= {in_colour, in_count};
        pair_idx <= '0;
      end
      ST_COPY: begin
        pair_idx  <= pair_idx + PIW'(1);
        new_valid <= 1'b0;
        new_link  <= '0;
        link_cur  <= 1'b0;
      end
      ST_HEAD: begin
        if (ent_rd.key < new_key) begin
          // New entry becomes the head
          new_valid <= 1'b1;
          new_link  <= head;
          link_cur  <= 1'b0;
        end else begin
          cur       <= head;
          cur_ent   <= ent_rd;
          new_valid <= 1'b0;
          new_link  <= '0;
          link_cur  <= 1'b1;
        end
      end
      ST_WALK: begin
        if (ent_rd.key < new_key) begin
          // Insert between cur and the entry just read
          new_valid <= 1'b1;
          new_link  <= cur_ent.link;
        end else begin
          cur     <= cur_ent.link;
          cur_ent <= ent_rd;
        end
      end
      ST_EMIT_ENT: begin
        emit_ent <= ent_rd;
        emit_n   <= rd_n;
        pair_idx <= '0;
      end
      ST_EMIT_DATA: begin
        pair_idx <= pair_idx + PIW'(1);
      end
      default: begin
        pair_idx <= pair_idx;
      end
    endcase
  end

  dspl_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  dspl_ram #(
    .WIDTH (dspl_pkg::VERTEX_W),
    .DEPTH (VDEPTH)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (vtx_addr),
    .wdata (stage_rdata),
    .re    (vtx_re),
    .raddr (vtx_addr),
    .rdata (vtx_rdata)
  );

  dspl_stage #(
    .PAIRS (PAIRS)
  ) u_stage (
    .clk   (clk),
    .rst   (rst),
    .we    (stage_we),
    .widx  (in_vidx),
    .wdata (in_vertex),
    .ridx  (pair_idx),
    .rdata (stage_rdata)
  );

  dspl_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (out_res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `DSPL_ASSERT_ALWAYS(a_count_range, clk, rst, entry_count <= CW'(MAX_ENTRIES), "entry count above store size")
  `DSPL_ASSERT_NEXT(a_count_step, clk, rst, s_acc && (in_op == dspl_pkg::OP_INSERT) && !full, entry_count == $past(entry_count) + CW'(1), "insert did not claim a slot")
  `DSPL_ASSERT_IMPL(a_walk_slot, clk, rst, state == ST_WALK, cur != new_slot, "walk reached the slot being inserted")
  `DSPL_ASSERT_IMPL(a_ram_exclusive, clk, rst, ent_we, !ent_re && !vtx_re && !vtx_we, "entry write overlaps a RAM access")

endmodule

>>> sv/dspl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; contents are undefined until written.
module dspl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/dspl_stage.sv
// Staging register file for the vertex pairs of the next inserted primitive.
// Depends on dspl_pkg for the vertex width; cleared to zero by reset.
module dspl_stage #(
  parameter int PAIRS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [2:0]                          widx,
  input  logic [dspl_pkg::VERTEX_W-1:0]       wdata,
  input  logic [$clog2(PAIRS)-1:0]            ridx,
  output logic [dspl_pkg::VERTEX_W-1:0]       rdata
);

  logic [dspl_pkg::VERTEX_W-1:0] pairs [PAIRS];

  // Write the addressed pair; an index beyond the pairs held matches none
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PAIRS; j++) begin
        pairs[j] <= '0;
      end
    end else if (we) begin
      for (int j = 0; j < PAIRS; j++) begin
        if (32'(widx) == j) begin
          pairs[j] <= wdata;
        end
      end
    end
  end

  assign rdata = pairs[ridx];

endmodule

>>> sv/dspl_out_reg.sv
// Result register of the depth sorter: holds one result until the master side takes it.
// Depends on dspl_pkg for the result record and field widths.
`include "depth_sorted_primitive_list_macros.svh"

module dspl_out_reg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  dspl_pkg::result_t                 res,
  output logic                              free,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // entry_slot[6:0], out_point_count[10:7], out_colour[18:11], out_x[34:19],
  // out_y[50:35], zero fill [55:51]
  output logic [dspl_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [dspl_pkg::STATUS_W-1:0]     m_tuser,
  output logic                              m_tlast
);

  dspl_pkg::result_t held;

  // Valid flag: set on load, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {5'b0, held.y, held.x, held.colour, held.point_count, held.entry_slot};
  assign m_tuser = held.status;
  assign m_tlast = held.last;

  `DSPL_ASSERT_IMPL(a_no_overwrite, clk, rst, load, free, "result register loaded while occupied")
  `DSPL_ASSERT_NEXT(a_load_valid, clk, rst, load, m_tvalid, "loaded result not presented")
  `DSPL_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

>>> bench/depth_sorted_primitive_list_test.sv
// Self-checking bench for depth_sorted_primitive_list: a directed script, then random
// draw lists checked against an in-bench painter's-order list model.
// Depends on dspl_pkg and the depth_sorted_primitive_list RTL only.
`timescale 1ns / 1ps

module depth_sorted_primitive_list_test;

  localparam int SLOTS        = 128;
  localparam int POINT_WORDS  = 16;
  localparam int PAIRS        = POINT_WORDS / 2;
  localparam int RANDOM_ITEMS = 460;
  // longest insert walk plus margin
  localparam int SETTLE       = PAIRS + 4 + SLOTS + 24;
  localparam int SCRIPT_LEN   = 24;

  typedef struct packed {
    logic [dspl_pkg::OP_W-1:0]            op;
    logic [2:0]                           vidx;
    logic signed [dspl_pkg::COORD_W-1:0]  vx;
    logic signed [dspl_pkg::COORD_W-1:0]  vy;
    logic [dspl_pkg::COUNT_W-1:0]         pcount;
    logic [dspl_pkg::COLOUR_W-1:0]        colour;
    logic signed [dspl_pkg::DEPTH_W-1:0]  depth;
  } prim_op_t;

  typedef struct packed {
    prim_op_t                             cmd;
    logic                                 fixed;
    logic [dspl_pkg::STATUS_W-1:0]        fixed_status;
    logic [dspl_pkg::SLOT_OUT_W-1:0]      fixed_slot;
  } script_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [dspl_pkg::IN_DATA_W-1:0]   s_tdata = '0;
  logic [dspl_pkg::OP_W-1:0]        s_tuser = dspl_pkg::OP_CLEAR;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [dspl_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic [dspl_pkg::STATUS_W-1:0]    m_tuser;
  logic                             m_tlast;

  depth_sorted_primitive_list #(
    .MAX_ENTRIES(SLOTS),
    .POINT_WORDS(POINT_WORDS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Clock and a single reset pulse
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Painter's-order list model
  // ---------------------------------------------------------------------------
  logic signed [dspl_pkg::DEPTH_W-1:0]  prim_depth  [SLOTS];
  logic [dspl_pkg::COUNT_W-1:0]         prim_count  [SLOTS];
  logic [dspl_pkg::COLOUR_W-1:0]        prim_colour [SLOTS];
  logic [dspl_pkg::VERTEX_W-1:0]        prim_vertex [SLOTS][PAIRS];
  int                                   next_slot   [SLOTS];
  bit                                   has_next    [SLOTS];
  logic [dspl_pkg::VERTEX_W-1:0]        staged      [PAIRS];
  int                                   head = 0;
  int                                   entries = 0;
  int                                   walk_slot = 0;
  bit                                   walk_begun = 1'b0;
  bit                                   walk_over = 1'b0;

  dspl_pkg::result_t step_results [$];
  dspl_pkg::result_t due_results [$];

  // Receiver state, shared with the final check
  int                fault_count = 0;
  int                cycle_no = 0;
  int                ready_mode = 0;
  int                stall_left = 0;
  dspl_pkg::result_t seen;
  dspl_pkg::result_t want;

  initial begin
    foreach (staged[i]) staged[i] = '0;
  end

  function automatic void note_result(input logic [dspl_pkg::STATUS_W-1:0] st,
                                      input int slot,
                                      input logic [dspl_pkg::COUNT_W-1:0] cnt,
                                      input logic [dspl_pkg::COLOUR_W-1:0] col,
                                      input logic [dspl_pkg::VERTEX_W-1:0] xy,
                                      input bit fin);
    dspl_pkg::result_t r;
    r = '0;
    r.status      = st;
    r.entry_slot  = slot[dspl_pkg::SLOT_OUT_W-1:0];
    r.point_count = cnt;
    r.colour      = col;
    r.x           = xy[dspl_pkg::COORD_W-1:0];
    r.y           = xy[dspl_pkg::VERTEX_W-1:dspl_pkg::COORD_W];
    r.last        = fin;
    step_results.push_back(r);
  endfunction

  function automatic void rewind_walk();
    walk_slot  = head;
    walk_begun = 1'b0;
    walk_over  = 1'b0;
  endfunction

  // Advance the model by one operation; leave its results in step_results
  function automatic void depth_sort_step(input prim_op_t c);
    int slot, cur, n;
    step_results.delete();
    case (c.op)
      dspl_pkg::OP_CLEAR: begin
        entries = 0;
        head = 0;
        rewind_walk();
      end
      dspl_pkg::OP_VERTEX: begin
        if (c.vidx < PAIRS) staged[c.vidx] = {c.vy, c.vx};
      end
      dspl_pkg::OP_INSERT: begin
        if (entries >= SLOTS) begin
          note_result(dspl_pkg::STATUS_FULL, 0, '0, '0, '0, 1'b1);
        end else begin
          slot = entries;
          entries++;
          prim_depth[slot]  = c.depth;
          prim_count[slot]  = c.pcount;
          prim_colour[slot] = c.colour;
          for (int i = 0; i < PAIRS; i++) prim_vertex[slot][i] = staged[i];
          has_next[slot]  = 1'b0;
          next_slot[slot] = 0;
          if (slot == 0) begin
            head = 0;
          end else if ($signed(c.depth) > $signed(prim_depth[head])) begin
            next_slot[slot] = head;
            has_next[slot]  = 1'b1;
            head = slot;
          end else begin
            // walk past every entry at least as deep, so ties keep arrival order
            cur = head;
            while (has_next[cur] && $signed(prim_depth[next_slot[cur]]) >= $signed(c.depth))
              cur = next_slot[cur];
            if (has_next[cur]) begin
              next_slot[slot] = next_slot[cur];
              has_next[slot]  = 1'b1;
            end
            next_slot[cur] = slot;
            has_next[cur]  = 1'b1;
          end
          rewind_walk();
          note_result(dspl_pkg::STATUS_INSERTED, slot, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        if (!walk_begun) begin
          walk_begun = 1'b1;
          walk_slot  = head;
          walk_over  = (entries == 0);
        end
        if (walk_over || walk_slot >= entries) begin
          walk_over = 1'b1;
          note_result(dspl_pkg::STATUS_END, 0, '0, '0, '0, 1'b1);
        end else begin
          slot = walk_slot;
          n = int'(prim_count[slot]);
          if (n > PAIRS) n = PAIRS;
          if (n > dspl_pkg::MAX_EMIT) n = dspl_pkg::MAX_EMIT;
          if (n == 0)
            note_result(dspl_pkg::STATUS_VERTEX, slot, prim_count[slot], prim_colour[slot],
                        '0, 1'b1);
          for (int i = 0; i < n; i++)
            note_result(dspl_pkg::STATUS_VERTEX, slot, prim_count[slot], prim_colour[slot],
                        prim_vertex[slot][i], i + 1 == n);
          if (has_next[slot]) walk_slot = next_slot[slot];
          else walk_over = 1'b1;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int issued = 0;
  int burst_left = 1;
  bit valid_up = 1'b0;

  task automatic send_item(input prim_op_t c, input bit fixed,
                           input dspl_pkg::result_t fixed_res);
    depth_sort_step(c);
    if (fixed) due_results.push_back(fixed_res);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    issued++;
    s_tuser  <= c.op;
    s_tdata  <= {1'b0, c.depth, c.colour, c.pcount, c.vy, c.vx, c.vidx};
    s_tvalid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(4, 9)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
      // now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
    end
  endtask

  // Stop sending until every awaited result is in, then let the block settle
  task automatic hold_until_drained();
    if (valid_up) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [dspl_pkg::COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return dspl_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [dspl_pkg::DEPTH_W-1:0] pick_depth();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    // a narrow band produces plenty of equal depths
    if (sel < 4) return int'($urandom_range(0, 4)) - 2;
    if (sel == 4) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic prim_op_t random_cmd(input logic [dspl_pkg::OP_W-1:0] op);
    prim_op_t c;
    c.op     = op;
    c.vidx   = 3'($urandom_range(0, 7));
    c.vx     = pick_coord();
    c.vy     = pick_coord();
    c.pcount = ($urandom_range(0, 5) == 0) ? dspl_pkg::COUNT_W'($urandom_range(9, 15))
                                           : dspl_pkg::COUNT_W'($urandom_range(0, 8));
    c.colour = dspl_pkg::COLOUR_W'($urandom_range(0, 255));
    c.depth  = pick_depth();
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  script_row_t script [SCRIPT_LEN];

  initial begin
    dspl_pkg::result_t lit;
    int nprims, drain;
    bit filled;

    filled = 1'b0;
    script = '{
      // empty list after reset, and the end marker repeats
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd5, 16'h1234, 16'h4321, 4'd9,  8'h11, 32'h0000_0001}, 1'b1,
        dspl_pkg::STATUS_END, 7'd0},
      // zero-point entry built from the reset staging
      '{'{dspl_pkg::OP_INSERT, 3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_INSERTED, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_END, 7'd0},
      // coordinate extremes at the first and last staged pair
      '{'{dspl_pkg::OP_VERTEX, 3'd0, 16'h8000, 16'h7FFF, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_VERTEX, 3'd7, 16'h7FFF, 16'h8000, 4'd15, 8'hFF, 32'hFFFF_FFFF}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_VERTEX, 3'd3, 16'hFFFF, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      // deepest goes to the head, shallowest to the tail, equal depth after its twin
      '{'{dspl_pkg::OP_INSERT, 3'd0, 16'h0000, 16'h0000, 4'd8,  8'hFF, 32'h7FFF_FFFF}, 1'b1,
        dspl_pkg::STATUS_INSERTED, 7'd1},
      '{'{dspl_pkg::OP_INSERT, 3'd0, 16'h0000, 16'h0000, 4'd15, 8'hA5, 32'h8000_0000}, 1'b1,
        dspl_pkg::STATUS_INSERTED, 7'd2},
      '{'{dspl_pkg::OP_INSERT, 3'd0, 16'h0000, 16'h0000, 4'd2,  8'h5A, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_INSERTED, 7'd3},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      // insert in mid-drain sends the next emit back to the head
      '{'{dspl_pkg::OP_INSERT, 3'd0, 16'h0000, 16'h0000, 4'd3,  8'h3C, 32'h0000_0005}, 1'b1,
        dspl_pkg::STATUS_INSERTED, 7'd4},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_END, 7'd0},
      // clear empties the list but keeps the staged pairs
      '{'{dspl_pkg::OP_CLEAR,  3'd6, 16'h5555, 16'hAAAA, 4'd5,  8'h77, 32'h1234_5678}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_INSERT, 3'd0, 16'h0000, 16'h0000, 4'd7,  8'h81, 32'hFFFF_FFFF}, 1'b1,
        dspl_pkg::STATUS_INSERTED, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b0,
        dspl_pkg::STATUS_END, 7'd0},
      '{'{dspl_pkg::OP_EMIT,   3'd0, 16'h0000, 16'h0000, 4'd0,  8'h00, 32'h0000_0000}, 1'b1,
        dspl_pkg::STATUS_END, 7'd0}
    };

    do @(posedge clk); while (rst);

    // directed script
    foreach (script[i]) begin
      lit = '0;
      lit.status     = script[i].fixed_status;
      lit.entry_slot = script[i].fixed_slot;
      lit.last       = 1'b1;
      send_item(script[i].cmd, script[i].fixed, lit);
    end
    hold_until_drained();

    // random draw lists
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (!filled && issued >= 120) begin
        // fill the store, overflow it, then drain the whole list
        filled = 1'b1;
        hold_until_drained();
        send_item(random_cmd(dspl_pkg::OP_CLEAR), 1'b0, '0);
        repeat (3) send_item(random_cmd(dspl_pkg::OP_VERTEX), 1'b0, '0);
        repeat (SLOTS + 3) send_item(random_cmd(dspl_pkg::OP_INSERT), 1'b0, '0);
        repeat (SLOTS + 2) send_item(random_cmd(dspl_pkg::OP_EMIT), 1'b0, '0);
      end else begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 6))
            send_item(random_cmd(dspl_pkg::OP_W'($urandom_range(0, 3))), 1'b0, '0);
        if ($urandom_range(0, 4) != 0) send_item(random_cmd(dspl_pkg::OP_CLEAR), 1'b0, '0);
        nprims = $urandom_range(1, 10);
        repeat (nprims) begin
          repeat ($urandom_range(0, 8)) send_item(random_cmd(dspl_pkg::OP_VERTEX), 1'b0, '0);
          if ($urandom_range(0, 7) == 0) send_item(random_cmd(dspl_pkg::OP_EMIT), 1'b0, '0);
          send_item(random_cmd(dspl_pkg::OP_INSERT), 1'b0, '0);
        end
        // usually drain past the end, sometimes stop part way
        drain = entries + $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) drain = $urandom_range(0, entries);
        repeat (drain) send_item(random_cmd(dspl_pkg::OP_EMIT), 1'b0, '0);
        if ($urandom_range(0, 5) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern and result check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.status      = m_tuser;
      seen.entry_slot  = m_tdata[6:0];
      seen.point_count = m_tdata[10:7];
      seen.colour      = m_tdata[18:11];
      seen.x           = m_tdata[34:19];
      seen.y           = m_tdata[50:35];
      seen.last        = m_tlast;
      if (due_results.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected transfer: status %0d slot %0d at %0t",
                   seen.status, seen.entry_slot, $realtime);
        fault_count++;
      end else begin
        want = due_results.pop_front();
        if (seen.status !== want.status || seen.entry_slot !== want.entry_slot ||
            seen.point_count !== want.point_count || seen.colour !== want.colour ||
            seen.x !== want.x || seen.y !== want.y || seen.last !== want.last) begin
          if (fault_count < 10) begin
            $write("mismatch at %0t: expected st %0d slot %0d cnt %0d col %0d x %0d y %0d",
                   $realtime, want.status, want.entry_slot, want.point_count, want.colour,
                   want.x, want.y);
            $display(" last %0d, got st %0d slot %0d cnt %0d col %0d x %0d y %0d last %0d",
                     want.last, seen.status, seen.entry_slot, seen.point_count, seen.colour,
                     seen.x, seen.y, seen.last);
          end
          fault_count++;
        end
      end
    end

    // switch stall style periodically
    cycle_no++;
    if (cycle_no % 100 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= (cycle_no % 5 != 2);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 12);
        end
      end
    endcase
  end

endmodule

>>> depth_sorted_primitive_list.f
+incdir+sv
sv/dspl_pkg.sv
sv/dspl_ram.sv
sv/dspl_stage.sv
sv/dspl_out_reg.sv
sv/depth_sorted_primitive_list.sv
bench/depth_sorted_primitive_list_test.sv
